@@ rtl/core/spd_pkg.sv @@
package spd_pkg;

    // Input commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_DECODE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Width of the shared arithmetic unit: a 16-bit page word plus one bit of headroom
    localparam int ALU_W = 17;

    // Arithmetic unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;   // carry out on add, borrow on subtract
    } t_alu_rsp;

endpackage

@@ rtl/core/spd_ram.sv @@
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/spd_alu.sv @@
module spd_alu
    import spd_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] w_sum;

    // Add or subtract with one extra bit for carry or borrow
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
    end

    assign o_rsp.res   = w_sum[ALU_W-1:0];
    assign o_rsp.carry = w_sum[ALU_W];

endmodule

@@ rtl/core/sprite_post_decoder.sv @@
// Column-post sprite decoder.
// Input channel (i_valid/o_ready) takes one command per transaction: load a page
// byte, decode the loaded page into the square indexed frame, or read one pixel.
// Output channel (o_valid/i_ready) returns exactly one result per command: the
// pixel for a read (zero otherwise) plus the current box and error registers.
// The block works on one command at a time; o_ready is high only while idle.
// Steps from acceptance to o_valid, with the receiver ready:
//   read    frame memory read, response
//   load    address reduced modulo PAGE_BYTES by the shared compare-subtract
//           unit, one step a cycle, then the page write and the response
//   decode  frame clear, then a range check and two byte reads per post-list
//           word, a reduction per post, and a check and a write per pixel copied.
// The page memory has a single read port, so every word and pixel costs its own
// read cycles; that port and the shared unit set the decode rate.
// Reset starts a clearing pass over all SPRITE_SIZE^2 entries (4096 at the default) that
// zeroes the frame; o_ready stays low until it ends. Box and error registers reset
// to zero. A result that is not taken is held in the output register; the block
// takes the next command meanwhile, and holds its following result until the
// output register frees up.
module sprite_post_decoder
    import spd_pkg::*;
#(
    parameter int PAGE_BYTES  = 8192,
    parameter int SPRITE_SIZE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [12:0]       i_address,
    input  logic [7:0]        i_byte_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_pixel_opaque,
    output logic [7:0]        o_pixel_index,
    output logic [5:0]        o_box_left,
    output logic [6:0]        o_box_top,
    output logic [6:0]        o_box_width,
    output logic signed [7:0] o_box_height,
    output logic              o_decode_error
);

    localparam int AW        = $clog2(PAGE_BYTES);
    localparam int CW        = $clog2(SPRITE_SIZE);
    localparam int LW        = CW + 1;
    localparam int FDEPTH    = SPRITE_SIZE * SPRITE_SIZE;
    localparam int FW        = $clog2(FDEPTH);
    localparam int FLOG      = $clog2(PAGE_BYTES + 1) - 1;
    localparam int RED_STEPS = ALU_W - FLOG;
    localparam int KW        = $clog2(RED_STEPS + 1);

    // Sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RED   = 5'd2;
    localparam logic [4:0] S_LOADW = 5'd3;
    localparam logic [4:0] S_RD    = 5'd4;
    localparam logic [4:0] S_RESP  = 5'd5;
    localparam logic [4:0] S_HDR   = 5'd6;
    localparam logic [4:0] S_HDR2  = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_COL   = 5'd9;
    localparam logic [4:0] S_COLP  = 5'd10;
    localparam logic [4:0] S_END   = 5'd11;
    localparam logic [4:0] S_SRC   = 5'd12;
    localparam logic [4:0] S_BEG   = 5'd13;
    localparam logic [4:0] S_PIX   = 5'd14;
    localparam logic [4:0] S_PIXW  = 5'd15;
    localparam logic [4:0] S_NEXT  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;
    localparam logic [4:0] S_WCHK  = 5'd18;
    localparam logic [4:0] S_W1    = 5'd19;
    localparam logic [4:0] S_W2    = 5'd20;

    // Control registers
    logic [4:0]         r_state, n_state;
    logic               r_dec, n_dec;
    logic [FW-1:0]      r_cnt, n_cnt;
    logic               r_ov, n_ov;
    logic [5:0]         r_box_left, n_box_left;
    logic [6:0]         r_box_top, n_box_top;
    logic [6:0]         r_box_width, n_box_width;
    logic [7:0]         r_box_height, n_box_height;
    logic               r_err, n_err;

    // Working registers
    logic [4:0]         r_wret, n_wret;
    logic [4:0]         r_rret, n_rret;
    logic [1:0]         r_cmd, n_cmd;
    logic [12:0]        r_addr, n_addr;
    logic [7:0]         r_byte, n_byte;
    logic [ALU_W-1:0]   r_pos, n_pos;
    logic [15:0]        r_word, n_word;
    logic [7:0]         r_lo, n_lo;
    logic               r_wfail, n_wfail;
    logic [15:0]        r_first, n_first;
    logic [CW-1:0]      r_last_x, n_last_x;
    logic [CW-1:0]      r_x, n_x;
    logic [CW-1:0]      r_xoff, n_xoff;
    logic [15:0]        r_src, n_src;
    logic [14:0]        r_end, n_end;
    logic [14:0]        r_y, n_y;
    logic [LW-1:0]      r_lim, n_lim;
    logic [ALU_W-1:0]   r_red, n_red;
    logic [KW-1:0]      r_k, n_k;
    logic signed [16:0] r_min_y, n_min_y;
    logic signed [16:0] r_max_y, n_max_y;

    // Output register
    logic               r_o_opaque, n_o_opaque;
    logic [7:0]         r_o_index, n_o_index;
    logic [5:0]         r_o_left, n_o_left;
    logic [6:0]         r_o_top, n_o_top;
    logic [6:0]         r_o_width, n_o_width;
    logic [7:0]         r_o_height, n_o_height;
    logic               r_o_err, n_o_err;

    // Shared unit and memories
    t_alu_req           w_alu_req;
    t_alu_rsp           w_alu_rsp;
    logic               w_page_we;
    logic [AW-1:0]      w_page_raddr;
    logic [7:0]         w_page_rdata;
    logic               w_frame_we;
    logic [FW-1:0]      w_frame_waddr;
    logic [8:0]         w_frame_wdata;
    logic [8:0]         w_frame_rdata;

    // Helpers
    logic [14:0]        w_beg;
    logic signed [16:0] w_ctop;
    logic signed [16:0] w_chgt;
    logic [CW-1:0]      w_row;
    logic               w_rd_hit;
    logic               w_wfail_now;

    assign w_beg  = r_word[15:1];
    assign w_ctop = $signed(17'(SPRITE_SIZE - 1)) - $signed({2'b00, w_beg});
    assign w_chgt = $signed(17'(SPRITE_SIZE)) - $signed({2'b00, r_end});
    assign w_row  = CW'(SPRITE_SIZE - 1) - r_y[CW-1:0];
    assign w_rd_hit = (r_cmd == CMD_READ) && (32'(r_addr) < FDEPTH);
    assign w_wfail_now = w_alu_rsp.carry || (w_alu_rsp.res < ALU_W'(2));

    // Route operands to the shared unit by state
    always_comb begin
        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = r_red;
        w_alu_req.b  = ALU_W'(PAGE_BYTES) << r_k;
        unique case (r_state)
            S_CHK: begin
                w_alu_req.a = {1'b0, r_word};
                w_alu_req.b = {1'b0, r_first};
            end
            S_BEG: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = {1'b0, r_src};
                w_alu_req.b  = {2'b00, w_beg};
            end
            S_WCHK: begin
                w_alu_req.a = ALU_W'(PAGE_BYTES);
                w_alu_req.b = r_pos;
            end
            S_PIX: begin
                w_alu_req.a = ALU_W'(r_y);
                w_alu_req.b = ALU_W'(r_lim);
            end
            default: begin
            end
        endcase
    end

    spd_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // Page memory port selection
    always_comb begin
        unique case (r_state)
            S_WCHK:  w_page_raddr = r_pos[AW-1:0];
            S_W1:    w_page_raddr = AW'(r_pos + ALU_W'(1));
            default: w_page_raddr = r_red[AW-1:0];
        endcase
    end

    assign w_page_we = (r_state == S_LOADW);

    spd_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page (
        .i_clk   (i_clk),
        .i_we    (w_page_we),
        .i_waddr (r_red[AW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (w_page_raddr),
        .o_rdata (w_page_rdata)
    );

    // Frame memory: clearing sweep or post pixel write
    always_comb begin
        w_frame_we    = 1'b0;
        w_frame_waddr = r_cnt;
        w_frame_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_frame_we = 1'b1;
        end else if (r_state == S_PIXW) begin
            w_frame_we    = 1'b1;
            w_frame_waddr = FW'(row_index(w_row, r_x));
            w_frame_wdata = {1'b1, w_page_rdata};
        end
    end

    function automatic logic [FW-1:0] row_index(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        logic [FW-1:0] base;
        base = FW'(row) * FW'(SPRITE_SIZE);
        return base + FW'(col);
    endfunction

    spd_ram #(
        .WIDTH (9),
        .DEPTH (FDEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_frame_we),
        .i_waddr (w_frame_waddr),
        .i_wdata (w_frame_wdata),
        .i_raddr (FW'(r_addr)),
        .o_rdata (w_frame_rdata)
    );

    assign o_ready = (r_state == S_IDLE);

    // Sequencer next state and datapath
    always_comb begin
        n_state      = r_state;
        n_dec        = r_dec;
        n_cnt        = r_cnt;
        n_ov         = r_ov;
        n_box_left   = r_box_left;
        n_box_top    = r_box_top;
        n_box_width  = r_box_width;
        n_box_height = r_box_height;
        n_err        = r_err;
        n_wret       = r_wret;
        n_rret       = r_rret;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_byte       = r_byte;
        n_pos        = r_pos;
        n_word       = r_word;
        n_lo         = r_lo;
        n_wfail      = r_wfail;
        n_first      = r_first;
        n_last_x     = r_last_x;
        n_x          = r_x;
        n_xoff       = r_xoff;
        n_src        = r_src;
        n_end        = r_end;
        n_y          = r_y;
        n_lim        = r_lim;
        n_red        = r_red;
        n_k          = r_k;
        n_min_y      = r_min_y;
        n_max_y      = r_max_y;
        n_o_opaque   = r_o_opaque;
        n_o_index    = r_o_index;
        n_o_left     = r_o_left;
        n_o_top      = r_o_top;
        n_o_width    = r_o_width;
        n_o_height   = r_o_height;
        n_o_err      = r_o_err;

        // Release the output register once taken
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + FW'(1);
                if (r_cnt == FW'(FDEPTH - 1)) begin
                    n_cnt = '0;
                    if (r_dec) begin
                        n_dec   = 1'b0;
                        n_state = S_HDR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = i_command;
                    n_addr = i_address;
                    n_byte = i_byte_value;
                    unique case (i_command)
                        CMD_LOAD: begin
                            n_red   = ALU_W'(i_address);
                            n_k     = KW'(RED_STEPS - 1);
                            n_rret  = S_LOADW;
                            n_state = S_RED;
                        end
                        CMD_DECODE: begin
                            n_dec       = 1'b1;
                            n_cnt       = '0;
                            n_err       = 1'b0;
                            n_box_left  = '0;
                            n_box_width = '0;
                            n_min_y     = 17'(SPRITE_SIZE);
                            n_max_y     = '0;
                            n_state     = S_CLEAR;
                        end
                        CMD_READ: n_state = S_RD;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_RED: begin
                // Subtract the shifted page size where it fits
                if (!w_alu_rsp.carry) begin
                    n_red = w_alu_rsp.res;
                end
                if (r_k == '0) begin
                    n_state = r_rret;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            S_LOADW: n_state = S_RESP;
            S_RD:    n_state = S_RESP;
            S_RESP: begin
                if (!r_ov || i_ready) begin
                    n_ov         = 1'b1;
                    n_o_opaque   = w_rd_hit & w_frame_rdata[8];
                    n_o_index    = w_rd_hit ? w_frame_rdata[7:0] : 8'd0;
                    n_o_left     = r_box_left;
                    n_o_top      = r_box_top;
                    n_o_width    = r_box_width;
                    n_o_height   = r_box_height;
                    n_o_err      = r_err;
                    n_state      = S_IDLE;
                end
            end
            S_HDR: begin
                n_pos   = '0;
                n_wret  = S_HDR2;
                n_state = S_WCHK;
            end
            S_HDR2: begin
                n_first = r_word;
                n_wret  = S_CHK;
                n_state = S_WCHK;
            end
            S_CHK: begin
                // Reject a reversed or oversized column range
                if (w_alu_rsp.carry || (32'(r_word) >= SPRITE_SIZE)) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_box_left  = 6'(r_first);
                    n_box_width = 7'(w_alu_rsp.res + ALU_W'(1));
                    n_last_x    = r_word[CW-1:0];
                    n_x         = r_first[CW-1:0];
                    n_xoff      = '0;
                    n_state     = S_COL;
                end
            end
            S_COL: begin
                n_pos   = ALU_W'(4) + (ALU_W'(r_xoff) << 1);
                n_wret  = S_COLP;
                n_state = S_WCHK;
            end
            S_COLP: begin
                if (r_wfail) begin
                    n_err   = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_pos   = {1'b0, r_word};
                    n_wret  = S_END;
                    n_state = S_WCHK;
                end
            end
            S_END: begin
                if (r_wfail) begin
                    n_err   = 1'b1;
                    n_state = S_NEXT;
                end else if (r_word[15:1] == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_end   = r_word[15:1];
                    n_wret  = S_SRC;
                    n_state = S_WCHK;
                end
            end
            S_SRC: begin
                if (r_wfail) begin
                    n_err   = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_src   = r_word;
                    n_wret  = S_BEG;
                    n_state = S_WCHK;
                end
            end
            S_BEG: begin
                if (r_wfail) begin
                    n_err   = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    // Source start wraps at 16 bits, then reduce to the page
                    n_red  = {1'b0, w_alu_rsp.res[15:0]};
                    n_k    = KW'(RED_STEPS - 1);
                    n_rret = S_PIX;
                    n_y    = w_beg;
                    if (32'(r_end) > SPRITE_SIZE) begin
                        n_lim = LW'(SPRITE_SIZE);
                        if (w_beg < r_end) begin
                            n_err = 1'b1;
                        end
                    end else begin
                        n_lim = LW'(r_end);
                    end
                    if (w_ctop < r_min_y) begin
                        n_min_y = w_ctop;
                    end
                    if (w_chgt > r_max_y) begin
                        n_max_y = w_chgt;
                    end
                    n_state = S_RED;
                end
            end
            S_PIX: begin
                if (w_alu_rsp.carry) begin
                    n_state = S_PIXW;
                end else begin
                    n_wret  = S_END;
                    n_state = S_WCHK;
                end
            end
            S_PIXW: begin
                n_y     = r_y + 15'(1);
                n_red   = (r_red == ALU_W'(PAGE_BYTES - 1)) ? '0 : r_red + ALU_W'(1);
                n_state = S_PIX;
            end
            S_NEXT: begin
                if (r_x == r_last_x) begin
                    n_state = S_FIN;
                end else begin
                    n_x     = r_x + CW'(1);
                    n_xoff  = r_xoff + CW'(1);
                    n_state = S_COL;
                end
            end
            S_FIN: begin
                n_box_top    = r_min_y[6:0];
                n_box_height = 8'(r_max_y - r_min_y + 17'sd1);
                n_state      = S_RESP;
            end
            S_WCHK: begin
                // Refuse a word that would pass the page end
                if (w_wfail_now) begin
                    n_wfail = 1'b1;
                    n_state = r_wret;
                end else begin
                    n_wfail = 1'b0;
                    n_state = S_W1;
                end
            end
            S_W1: begin
                n_lo    = w_page_rdata;
                n_state = S_W2;
            end
            S_W2: begin
                n_word  = {w_page_rdata, r_lo};
                n_pos   = r_pos + ALU_W'(2);
                n_state = r_wret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_dec        <= 1'b0;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_width  <= '0;
            r_box_height <= '0;
            r_err        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dec        <= n_dec;
            r_cnt        <= n_cnt;
            r_ov         <= n_ov;
            r_box_left   <= n_box_left;
            r_box_top    <= n_box_top;
            r_box_width  <= n_box_width;
            r_box_height <= n_box_height;
            r_err        <= n_err;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_wret     <= n_wret;
        r_rret     <= n_rret;
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_byte     <= n_byte;
        r_pos      <= n_pos;
        r_word     <= n_word;
        r_lo       <= n_lo;
        r_wfail    <= n_wfail;
        r_first    <= n_first;
        r_last_x   <= n_last_x;
        r_x        <= n_x;
        r_xoff     <= n_xoff;
        r_src      <= n_src;
        r_end      <= n_end;
        r_y        <= n_y;
        r_lim      <= n_lim;
        r_red      <= n_red;
        r_k        <= n_k;
        r_min_y    <= n_min_y;
        r_max_y    <= n_max_y;
        r_o_opaque <= n_o_opaque;
        r_o_index  <= n_o_index;
        r_o_left   <= n_o_left;
        r_o_top    <= n_o_top;
        r_o_width  <= n_o_width;
        r_o_height <= n_o_height;
        r_o_err    <= n_o_err;
    end

    assign o_valid        = r_ov;
    assign o_pixel_opaque = r_o_opaque;
    assign o_pixel_index  = r_o_index;
    assign o_box_left     = r_o_left;
    assign o_box_top      = r_o_top;
    assign o_box_width    = r_o_width;
    assign o_box_height   = $signed(r_o_height);
    assign o_decode_error = r_o_err;

endmodule

@@ rtl/core/spd_chk.sv @@
module spd_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [1:0]        i_command,
    input logic [12:0]       i_address,
    input logic [7:0]        i_byte_value,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_pixel_opaque,
    input logic [7:0]        o_pixel_index,
    input logic [5:0]        o_box_left,
    input logic [6:0]        o_box_top,
    input logic [6:0]        o_box_width,
    input logic signed [7:0] o_box_height,
    input logic              o_decode_error
);

    // Reset starts the frame clear: nothing offered, nothing accepted
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output valid or input ready right after reset");

    // One command at a time: ready drops after each accepted transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready held after an accepted transaction");

    // A transparent pixel carries index zero
    a_transparent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_opaque |-> o_pixel_index == 8'd0)
        else $error("transparent pixel with nonzero index");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_index)
            && $stable(o_box_height) && $stable(o_decode_error))
        else $error("stalled result changed");

endmodule

bind sprite_post_decoder spd_chk u_spd_chk (.*);

@@ tb/sv/tb.sv @@
module tb;
    import spd_pkg::*;

    localparam int PAGE_BYTES   = 8192;
    localparam int SPRITE       = 64;
    localparam int FRAME_PIXELS = SPRITE * SPRITE;

    // Command 3 has no function in the block; it still answers with one result
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 100;
    localparam int RUN_LIMIT    = 20_000_000;

    // One result transaction as the block presents it
    typedef struct packed {
        logic       opaque;
        logic [7:0] index;
        logic [5:0] left;
        logic [6:0] top;
        logic [6:0] width;
        logic [7:0] height;
        logic       err;
    } pixel_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_command;
    logic [12:0]       i_address;
    logic [7:0]        i_byte_value;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_pixel_opaque;
    logic [7:0]        o_pixel_index;
    logic [5:0]        o_box_left;
    logic [6:0]        o_box_top;
    logic [6:0]        o_box_width;
    logic signed [7:0] o_box_height;
    logic              o_decode_error;

    // Mirror of the block state
    logic [7:0] page_img [PAGE_BYTES];
    logic [8:0] frame_img [FRAME_PIXELS];
    int         box_l = 0;
    int         box_t = 0;
    int         box_w = 0;
    int         box_h = 0;
    bit         err_img = 1'b0;

    pixel_result_t pending_results [$];

    int          err_count = 0;
    int unsigned items_sent = 0;
    int unsigned n_loads = 0;
    int unsigned n_decodes = 0;
    int unsigned n_decode_errs = 0;
    int unsigned n_reads = 0;
    int unsigned n_checked = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Receiver hold-off request counter and its countdown
    int unsigned stall_asks = 0;
    int unsigned stall_taken = 0;
    int unsigned stall_left = 0;

    // Sprite currently laid out in the page, and whether a decode of it stays bounded
    bit          page_sane = 1'b0;
    int unsigned sprite_first = 0;
    int unsigned sprite_last = 0;

    sprite_post_decoder #(
        .PAGE_BYTES  (PAGE_BYTES),
        .SPRITE_SIZE (SPRITE)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_byte_value   (i_byte_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_opaque (o_pixel_opaque),
        .o_pixel_index  (o_pixel_index),
        .o_box_left     (o_box_left),
        .o_box_top      (o_box_top),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .o_decode_error (o_decode_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Read a little-endian page word; refuse a read that runs past the page end
    function automatic bit fetch_word(inout int unsigned pos, output int unsigned val);
        if (pos + 2 > PAGE_BYTES) return 1'b0;
        val = {page_img[(pos + 1) % PAGE_BYTES], page_img[pos % PAGE_BYTES]};
        pos += 2;
        return 1'b1;
    endfunction

    // Walk the column post lists of the page into the frame mirror and track the box
    function automatic void decode_model_frame();
        int unsigned pos, first_col, last_col, tpos, cpos, endw, srcw, begw;
        int unsigned end_y, beg_y, src, lim;
        int          min_y, max_y;
        pos = 0;
        first_col = 0;
        last_col = 0;
        min_y = SPRITE;
        max_y = 0;
        foreach (frame_img[i]) frame_img[i] = '0;
        err_img = 1'b0;
        box_l = 0;
        box_w = 0;
        void'(fetch_word(pos, first_col));
        void'(fetch_word(pos, last_col));
        if (first_col > last_col || last_col >= SPRITE) begin
            err_img = 1'b1;
        end else begin
            box_l = first_col;
            box_w = last_col - first_col + 1;
            for (int unsigned x = first_col; x <= last_col; x++) begin
                tpos = 4 + 2 * (x - first_col);
                if (!fetch_word(tpos, cpos)) begin
                    err_img = 1'b1;
                    continue;
                end
                if (!fetch_word(cpos, endw)) begin
                    err_img = 1'b1;
                    continue;
                end
                while (endw / 2 > 0) begin
                    end_y = endw / 2;
                    if (!fetch_word(cpos, srcw) || !fetch_word(cpos, begw)) begin
                        err_img = 1'b1;
                        break;
                    end
                    beg_y = begw / 2;
                    src = (srcw + beg_y) % 65536;
                    lim = end_y;
                    // Clip rows that fall below the frame
                    if (lim > SPRITE) begin
                        lim = SPRITE;
                        if (beg_y < end_y) err_img = 1'b1;
                    end
                    for (int unsigned y = beg_y; y < lim; y++) begin
                        frame_img[(SPRITE - 1 - y) * SPRITE + x] =
                            {1'b1, page_img[(src + y - beg_y) % PAGE_BYTES]};
                    end
                    if (SPRITE - 1 - int'(beg_y) < min_y) min_y = SPRITE - 1 - int'(beg_y);
                    if (SPRITE - int'(end_y) > max_y) max_y = SPRITE - int'(end_y);
                    if (!fetch_word(cpos, endw)) begin
                        err_img = 1'b1;
                        break;
                    end
                end
            end
        end
        box_t = min_y;
        box_h = max_y - min_y + 1;
    endfunction

    // Apply one accepted command to the mirror and queue the result it must produce
    function automatic void predict_result(logic [1:0] cmd, logic [12:0] addr, logic [7:0] val);
        pixel_result_t r;
        logic [8:0]    pix;
        pix = '0;
        case (cmd)
            CMD_LOAD: begin
                page_img[addr % PAGE_BYTES] = val;
                n_loads++;
            end
            CMD_DECODE: begin
                decode_model_frame();
                n_decodes++;
                if (err_img) n_decode_errs++;
            end
            CMD_READ: begin
                if (addr < FRAME_PIXELS) pix = frame_img[addr];
                n_reads++;
            end
            default: ;
        endcase
        r.opaque = pix[8];
        r.index  = pix[7:0];
        r.left   = 6'(box_l);
        r.top    = 7'(box_t);
        r.width  = 7'(box_w);
        r.height = 8'(box_h);
        r.err    = err_img;
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // Compare each result transaction with the oldest prediction; drive receiver ready
    always @(posedge i_clk) begin : check_results
        pixel_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing pending, expected none, got index %0h",
                         $time, o_pixel_index);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("pixel_opaque", want.opaque, o_pixel_opaque);
                check_field("pixel_index", want.index, o_pixel_index);
                check_field("box_left", want.left, o_box_left);
                check_field("box_top", want.top, o_box_top);
                check_field("box_width", want.width, o_box_width);
                check_field("box_height", want.height, $unsigned(o_box_height));
                check_field("decode_error", want.err, o_decode_error);
            end
        end
        i_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Count down a receiver hold-off each time one is asked for
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_asks != stall_taken) begin
            stall_left  <= STALL_CYCLES;
            stall_taken <= stall_asks;
        end
    end

    // Offer one command, hold it until accepted, then predict its result
    task automatic send_item(input logic [1:0] cmd, input logic [12:0] addr,
                             input logic [7:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_address    <= addr;
        i_byte_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_result(cmd, addr, val);
        if (cmd != CMD_SPARE) items_sent++;
    endtask

    task automatic write_word(input int unsigned addr, input int unsigned val);
        send_item(CMD_LOAD, 13'(addr), val[7:0]);
        send_item(CMD_LOAD, 13'(addr + 1), val[15:8]);
    endtask

    task automatic send_decode();
        send_item(CMD_DECODE, 13'($urandom), 8'($urandom));
    endtask

    // Read pixels inside the given columns, plus one anywhere in the address space
    task automatic read_pixels(input int unsigned first_col, input int unsigned last_col,
                               input int unsigned count);
        int unsigned col, row;
        repeat (count) begin
            col = $urandom_range(first_col, last_col);
            row = $urandom_range(0, SPRITE - 1);
            send_item(CMD_READ, 13'(row * SPRITE + col), 8'($urandom));
        end
        send_item(CMD_READ, 13'($urandom), 8'($urandom));
    endtask

    // Lay out header, column offsets and post lists; source bytes come from the page
    task automatic build_sprite(input int unsigned first_col, input int unsigned last_col,
                                input int unsigned max_posts);
        int unsigned cursor, kind, beg_y, end_y;
        cursor = 4 + 2 * (last_col - first_col + 1) + $urandom_range(0, 7);
        write_word(0, first_col);
        write_word(2, last_col);
        for (int unsigned x = first_col; x <= last_col; x++) begin
            write_word(4 + 2 * (x - first_col), cursor);
            repeat ($urandom_range(0, max_posts)) begin
                kind = $urandom_range(0, 15);
                if (kind == 0) begin
                    // end row past the frame bottom
                    end_y = $urandom_range(65, 32767);
                    beg_y = $urandom_range(0, 80);
                end else if (kind == 1) begin
                    // start at or after end, possibly past the frame
                    end_y = $urandom_range(1, 64);
                    beg_y = $urandom_range(end_y, 127);
                end else begin
                    beg_y = $urandom_range(0, SPRITE - 1);
                    end_y = $urandom_range(beg_y + 1, SPRITE);
                end
                write_word(cursor, end_y * 2 + $urandom_range(0, 1));
                write_word(cursor + 2, $urandom_range(0, 65535));
                write_word(cursor + 4, beg_y * 2 + $urandom_range(0, 1));
                cursor += 6;
            end
            // terminate with an end word of 0 or 1
            write_word(cursor, $urandom_range(0, 1));
            cursor += 2;
        end
        sprite_first = first_col;
        sprite_last  = last_col;
        page_sane    = 1'b1;
    endtask

    task automatic test_reset_state();
        send_item(CMD_READ, 13'd0, 8'h00);
        send_item(CMD_READ, 13'(FRAME_PIXELS - 1), 8'hFF);
        send_item(CMD_READ, 13'(FRAME_PIXELS), 8'h5A);
        send_item(CMD_READ, 13'h1FFF, 8'hA5);
        send_item(CMD_SPARE, 13'h1FFF, 8'hFF);
    endtask

    // Write every page byte once so no decode ever meets an unwritten byte
    task automatic test_page_fill();
        for (int unsigned a = 0; a < PAGE_BYTES; a++)
            send_item(CMD_LOAD, 13'(a), 8'($urandom));
    endtask

    task automatic test_bad_column_range();
        write_word(0, 9);
        write_word(2, 3);
        send_decode();
        read_pixels(0, SPRITE - 1, 2);
        write_word(0, 0);
        write_word(2, SPRITE);
        send_decode();
        write_word(0, 16'hFFFF);
        write_word(2, 16'hFFFF);
        send_decode();
        read_pixels(0, SPRITE - 1, 1);
    endtask

    // Columns 10..16: empty column, rows past bottom, source wrap, start past frame,
    // list running off the page end in three ways
    task automatic test_special_columns();
        write_word(0, 10);
        write_word(2, 16);
        write_word(4, 32);
        write_word(6, 34);
        write_word(8, 42);
        write_word(10, 50);
        write_word(12, PAGE_BYTES - 4);
        write_word(14, PAGE_BYTES - 6);
        write_word(16, PAGE_BYTES - 1);
        write_word(32, 1);
        write_word(34, 200 * 2);
        write_word(36, 16'h0100);
        write_word(38, 50 * 2);
        write_word(40, 0);
        write_word(42, 20 * 2);
        write_word(44, 16'hFFFE);
        write_word(46, 5 * 2);
        write_word(48, 0);
        write_word(50, 90 * 2);
        write_word(52, 16'h0200);
        write_word(54, 70 * 2);
        write_word(56, SPRITE * 2);
        write_word(58, 16'h0300);
        write_word(60, 0);
        write_word(62, 0);
        write_word(PAGE_BYTES - 6, 40 * 2);
        write_word(PAGE_BYTES - 4, 16'h0150);
        write_word(PAGE_BYTES - 2, 35 * 2);
        send_decode();
        read_pixels(10, 16, 12);
        // empty sprite: only the column without posts
        write_word(2, 10);
        send_decode();
        read_pixels(10, 10, 2);
        page_sane = 1'b0;
    endtask

    task automatic test_full_width();
        build_sprite(0, SPRITE - 1, 1);
        send_decode();
        read_pixels(0, SPRITE - 1, 10);
        send_item(CMD_READ, 13'd0, 8'd0);
        send_item(CMD_READ, 13'(FRAME_PIXELS - 1), 8'd0);
    endtask

    task automatic test_random_sprites(input int unsigned item_budget);
        int unsigned start, kind, ncols, first_col, first_w, last_w;
        start = items_sent;
        while (items_sent - start < item_budget) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // broken header: reversed or out-of-frame column range
                if ($urandom_range(0, 1)) begin
                    last_w  = $urandom_range(SPRITE, 65535);
                    first_w = $urandom_range(0, 65535);
                end else begin
                    last_w  = $urandom_range(0, SPRITE - 2);
                    first_w = $urandom_range(last_w + 1, 65535);
                end
                write_word(0, first_w);
                write_word(2, last_w);
                send_decode();
                read_pixels(0, SPRITE - 1, 2);
                sprite_first = 0;
                sprite_last  = SPRITE - 1;
                page_sane    = 1'b1;
            end else if (kind == 1 && page_sane) begin
                // decode the same page again
                send_decode();
                read_pixels(sprite_first, sprite_last, 4);
            end else begin
                ncols = ($urandom_range(0, 31) == 0) ? $urandom_range(5, SPRITE)
                                                      : $urandom_range(1, 4);
                first_col = $urandom_range(0, SPRITE - ncols);
                build_sprite(first_col, first_col + ncols - 1, (ncols > 4) ? 1 : 3);
                send_decode();
                read_pixels(first_col, first_col + ncols - 1, 8);
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_SPARE, 13'($urandom), 8'($urandom));
                // stray loads anywhere; a rebuild must follow before walking lists again
                repeat ($urandom_range(0, 3)) begin
                    send_item(CMD_LOAD, 13'($urandom), 8'($urandom));
                    page_sane = 1'b0;
                end
            end
        end
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input
    task automatic test_output_backpressure();
        stall_asks <= stall_asks + 1;
        repeat (24) send_item(CMD_READ, 13'($urandom), 8'($urandom));
        send_item(CMD_SPARE, 13'($urandom), 8'($urandom));
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_LOAD;
        i_address    <= '0;
        i_byte_value <= '0;
        foreach (page_img[i]) page_img[i] = '0;
        foreach (frame_img[i]) frame_img[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 86;
        test_reset_state();
        test_page_fill();
        test_bad_column_range();
        test_special_columns();
        test_full_width();
        test_random_sprites(170);

        send_idle_pct = 86;
        recv_idle_pct = 18;
        test_random_sprites(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_sprites(170);

        // Drain outstanding results, then watch for any extra ones
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d page loads, %0d decodes (%0d flagged), %0d pixel reads;",
                 n_loads, n_decodes, n_decode_errs, n_reads);
        $display("%0d results checked across three idle patterns and one long hold-off.",
                 n_checked);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
